// ----- sv/nmit_pkg.sv -----
package nmit_pkg;

    // element and fraction defaults
    localparam int ELEM_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [15:0] THR_RST = 16'd7;

    // determinant magnitude and divider widths
    localparam int DET_W  = 99;
    localparam int DMAG_W = 98;
    localparam int QB     = 33;
    localparam int QR_W   = QB + 1;
    localparam int LANES  = 9;

    localparam logic [QR_W-1:0] LIM_POS = QR_W'(34'h0_7FFF_FFFF);
    localparam logic [QR_W-1:0] LIM_NEG = QR_W'(34'h0_8000_0000);

    typedef logic [3:0] t_idx;

    // cofactor k = m[a]*m[b] - m[c]*m[d], row-major element index
    localparam t_idx COF_IDX [LANES][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_r0c0;
        logic signed [ELEM_W-1:0] in_r0c1;
        logic signed [ELEM_W-1:0] in_r0c2;
        logic signed [ELEM_W-1:0] in_r1c0;
        logic signed [ELEM_W-1:0] in_r1c1;
        logic signed [ELEM_W-1:0] in_r1c2;
        logic signed [ELEM_W-1:0] in_r2c0;
        logic signed [ELEM_W-1:0] in_r2c1;
        logic signed [ELEM_W-1:0] in_r2c2;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_r0c0;
        logic signed [ELEM_W-1:0] out_r0c1;
        logic signed [ELEM_W-1:0] out_r0c2;
        logic signed [ELEM_W-1:0] out_r1c0;
        logic signed [ELEM_W-1:0] out_r1c1;
        logic signed [ELEM_W-1:0] out_r1c2;
        logic signed [ELEM_W-1:0] out_r2c0;
        logic signed [ELEM_W-1:0] out_r2c1;
        logic signed [ELEM_W-1:0] out_r2c2;
        logic                     singular;
        logic                     overflowed;
    } t_out;

    // one divider lane: partial remainder, quotient so far, numerator bits left
    typedef struct packed {
        logic [DMAG_W-1:0] rem;
        logic [QB-1:0]     quo;
        logic [QB-1:0]     nbits;
        logic              neg;
        logic              ovf;
    } t_lane;

    typedef struct packed {
        logic              sing;
        logic [DMAG_W-1:0] dmag;
        t_lane [LANES-1:0] lane;
    } t_dstage;

    // one restoring division step
    function automatic t_lane div_step(t_lane a, logic [DMAG_W-1:0] d);
        logic [DMAG_W:0] t;
        t_lane           b;
        b       = a;
        t       = {a.rem, a.nbits[QB-1]};
        b.nbits = {a.nbits[QB-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            b.rem = DMAG_W'(t - {1'b0, d});
            b.quo = {a.quo[QB-2:0], 1'b1};
        end else begin
            b.rem = t[DMAG_W-1:0];
            b.quo = {a.quo[QB-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage

// ----- sv/nmit_div.sv -----
module nmit_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  nmit_pkg::t_dstage i_stage,
    output logic              o_vld,
    output nmit_pkg::t_dstage o_stage
);
    import nmit_pkg::*;

    logic [QB:0] r_vld;
    t_dstage     r_st [QB+1];
    t_dstage     n_st [QB+1];

    // valid bits move with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QB-1:0], i_vld};
        end
    end

    // one quotient bit per stage, all lanes share the divisor
    always_comb begin
        n_st[0] = i_stage;
        for (int s = 0; s < QB; s++) begin
            n_st[s+1].sing = r_st[s].sing;
            n_st[s+1].dmag = r_st[s].dmag;
            for (int l = 0; l < LANES; l++) begin
                n_st[s+1].lane[l] = div_step(r_st[s].lane[l], r_st[s].dmag);
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld   = r_vld[QB];
    assign o_stage = r_st[QB];

endmodule

// ----- sv/normal_matrix_inverse_transpose.sv -----
// 3x3 normal matrix (inverse transpose) pipeline, one word per cycle unless stalled
// throughput: one word per cycle unless stalled; the 33-step divider pipeline sets the depth
// a stall at the output while a word is valid freezes the whole pipeline and holds the input
// synchronous active-low reset clears valid bits; threshold resets to 7
module normal_matrix_inverse_transpose #(
    parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  nmit_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output nmit_pkg::t_out o_data,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data
);
    import nmit_pkg::*;

    localparam int NW = 64 + 2 * FRAC_BITS;
    localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

    logic        w_en;
    logic [15:0] r_thr;
    logic [4:0]  r_vld;

    logic signed [ELEM_W-1:0] w_m [LANES];

    logic signed [63:0] r1_pa [LANES];
    logic signed [63:0] r1_pb [LANES];
    logic signed [ELEM_W-1:0] r1_m0 [3];

    logic signed [63:0] r2_c [LANES];
    logic signed [ELEM_W-1:0] r2_m0 [3];

    logic signed [64:0] r3_plo [3];
    logic signed [63:0] r3_phi [3];
    logic [63:0]        r3_cmag [LANES];
    logic [LANES-1:0]   r3_cneg;

    logic signed [DET_W-1:0] w_det;
    logic signed [DET_W-1:0] r4_det;
    logic [63:0]             r4_cmag [LANES];
    logic [LANES-1:0]        r4_cneg;

    logic [DET_W-1:0]  w_dabs;
    logic [DMAG_W-1:0] w_thr;
    logic [DMAG_W-1:0] r5_dmag;
    logic              r5_dneg;
    logic              r5_sing;
    logic [63:0]       r5_cmag [LANES];
    logic [LANES-1:0]  r5_cneg;

    t_dstage w_dinit;
    logic [NW-1:0] w_num [LANES];
    logic [DMAG_W-1:0] w_hi [LANES];

    logic    w_dvld;
    t_dstage w_dout;

    logic [ELEM_W-1:0] w_res [LANES];
    logic [QR_W-1:0]   w_qr  [LANES];
    logic [QR_W-1:0]   w_lim [LANES];
    logic [QR_W-1:0]   w_v   [LANES];
    logic [QR_W-1:0]   w_vs  [LANES];
    logic              w_any;
    t_out              n_out;
    t_out              r_out;
    logic              r_out_vld;

    // whole pipeline advances unless the output word is held
    assign w_en    = !r_out_vld || !i_stall;
    assign o_stall = !w_en;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // front stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], i_valid && !o_stall};
        end
    end

    assign w_m[0] = i_data.in_r0c0;
    assign w_m[1] = i_data.in_r0c1;
    assign w_m[2] = i_data.in_r0c2;
    assign w_m[3] = i_data.in_r1c0;
    assign w_m[4] = i_data.in_r1c1;
    assign w_m[5] = i_data.in_r1c2;
    assign w_m[6] = i_data.in_r2c0;
    assign w_m[7] = i_data.in_r2c1;
    assign w_m[8] = i_data.in_r2c2;

    // stage 1: cofactor products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < LANES; k++) begin
                r1_pa[k] <= w_m[COF_IDX[k][0]] * w_m[COF_IDX[k][1]];
                r1_pb[k] <= w_m[COF_IDX[k][2]] * w_m[COF_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) begin
                r1_m0[j] <= w_m[j];
            end
        end
    end

    // stage 2: cofactors, 64-bit wrapping difference
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < LANES; k++) begin
                r2_c[k] <= r1_pa[k] - r1_pb[k];
            end
            r2_m0 <= r1_m0;
        end
    end

    // stage 3: determinant partial products, cofactor magnitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r3_plo[j] <= r2_m0[j] * $signed({1'b0, r2_c[j][31:0]});
                r3_phi[j] <= r2_m0[j] * $signed(r2_c[j][63:32]);
            end
            for (int k = 0; k < LANES; k++) begin
                r3_cneg[k] <= r2_c[k][63];
                r3_cmag[k] <= r2_c[k][63] ? 64'(-r2_c[k]) : 64'(r2_c[k]);
            end
        end
    end

    // stage 4: determinant sum
    always_comb begin
        w_det = '0;
        for (int j = 0; j < 3; j++) begin
            w_det = w_det + (DET_W'(r3_phi[j]) <<< 32) + DET_W'(r3_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_det  <= w_det;
            r4_cmag <= r3_cmag;
            r4_cneg <= r3_cneg;
        end
    end

    // stage 5: magnitude and singular test
    assign w_dabs = r4_det[DET_W-1] ? DET_W'(-r4_det) : DET_W'(r4_det);
    assign w_thr  = DMAG_W'(r_thr) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_dmag <= w_dabs[DMAG_W-1:0];
            r5_dneg <= r4_det[DET_W-1];
            r5_sing <= (w_dabs == '0) || (w_dabs[DMAG_W-1:0] < w_thr);
            r5_cmag <= r4_cmag;
            r5_cneg <= r4_cneg;
        end
    end

    // divider entry: early overflow when quotient reaches 2^QB
    always_comb begin
        w_dinit.sing = r5_sing;
        w_dinit.dmag = r5_dmag;
        for (int l = 0; l < LANES; l++) begin
            w_num[l]               = NW'(r5_cmag[l]) << (2 * FRAC_BITS);
            w_hi[l]                = DMAG_W'(w_num[l][NW-1:QB]);
            w_dinit.lane[l].ovf    = w_hi[l] >= r5_dmag;
            w_dinit.lane[l].rem    = w_dinit.lane[l].ovf ? '0 : w_hi[l];
            w_dinit.lane[l].quo    = '0;
            w_dinit.lane[l].nbits  = w_num[l][QB-1:0];
            w_dinit.lane[l].neg    = r5_cneg[l] ^ r5_dneg;
        end
    end

    nmit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[4]),
        .i_stage (w_dinit),
        .o_vld   (w_dvld),
        .o_stage (w_dout)
    );

    // rounding half up on magnitude, then saturation and sign
    always_comb begin
        w_any = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            w_qr[l] = {1'b0, w_dout.lane[l].quo}
                    + QR_W'({w_dout.lane[l].rem, 1'b0} >= {1'b0, w_dout.dmag});
            w_lim[l] = w_dout.lane[l].neg ? LIM_NEG : LIM_POS;
            if (w_dout.lane[l].ovf || (w_qr[l] > w_lim[l])) begin
                w_v[l] = w_lim[l];
                w_any  = 1'b1;
            end else begin
                w_v[l] = w_qr[l];
            end
            w_vs[l]  = w_dout.lane[l].neg ? QR_W'(-w_v[l]) : w_v[l];
            w_res[l] = w_vs[l][ELEM_W-1:0];
        end
    end

    // output word, identity on singular
    always_comb begin
        if (w_dout.sing) begin
            n_out            = '0;
            n_out.out_r0c0   = ONE;
            n_out.out_r1c1   = ONE;
            n_out.out_r2c2   = ONE;
            n_out.singular   = 1'b1;
            n_out.overflowed = 1'b0;
        end else begin
            n_out.out_r0c0   = w_res[0];
            n_out.out_r0c1   = w_res[1];
            n_out.out_r0c2   = w_res[2];
            n_out.out_r1c0   = w_res[3];
            n_out.out_r1c1   = w_res[4];
            n_out.out_r1c2   = w_res[5];
            n_out.out_r2c0   = w_res[6];
            n_out.out_r2c1   = w_res[7];
            n_out.out_r2c2   = w_res[8];
            n_out.singular   = 1'b0;
            n_out.overflowed = w_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // checks
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_sing_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> !o_data.overflowed)
        else $error("singular word flagged overflow");

    a_sing_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> o_data.out_r0c0 == ONE
            && o_data.out_r1c1 == ONE && o_data.out_r0c1 == '0)
        else $error("singular word is not identity");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r4_det) && $stable(r_vld))
        else $error("pipeline moved while output held");

endmodule
